### src/fbc_pkg.sv
// Shared types and constants for the block FIR convolution filter.
// No dependencies; imported by fbc_cell, fbc_mac and fir_block_convolution.
package fbc_pkg;

  // Command codes carried in the slave-side tuser
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Fixed field widths of the stream payload
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned OUT_W   = 40;

  // Per-cycle controls broadcast to every tap cell
  typedef struct packed {
    logic load;    // write coefficient to the cell whose index matches
    logic shift;   // shift the delay line by one (new sample at the head)
    logic clear;   // with shift: zero the delay line behind the head
    logic rotate;  // rotate sample and coefficient around the ring
  } fbc_cell_ctrl_t;

  // Controls for the shared multiply-accumulate
  typedef struct packed {
    logic clr;     // zero the accumulator for a new request
    logic mult;    // a valid tap pair is presented this cycle
  } fbc_mac_ctrl_t;

endpackage

### src/fbc_cell.sv
// One tap cell: holds one delay-line sample and one coefficient.
// Depends on fbc_pkg; instantiated once per tap by fir_block_convolution.
module fbc_cell import fbc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 16,
  parameter int unsigned INDEX       = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fbc_cell_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]       coef_idx_i,
  input  logic [COEF_BITS-1:0]   coef_wr_i,
  input  logic [SAMPLE_BITS-1:0] prev_delay_i,
  input  logic [COEF_BITS-1:0]   prev_coef_i,
  output logic [SAMPLE_BITS-1:0] delay_o,
  output logic [COEF_BITS-1:0]   coef_o
);

  logic [SAMPLE_BITS-1:0] delay_q, delay_d;
  logic [COEF_BITS-1:0]   coef_q, coef_d;
  logic                   idx_hit;

  // Tap address decode against this cell's fixed position
  assign idx_hit = ({1'b0, coef_idx_i} == 8'(INDEX));

  // Next state: rotate for the MAC pass, shift on a new request, load on write
  always_comb begin
    delay_d = delay_q;
    coef_d  = coef_q;
    if (ctrl_i.rotate) begin
      delay_d = prev_delay_i;
      coef_d  = prev_coef_i;
    end else if (ctrl_i.shift) begin
      // head cell always takes the new sample; the rest clear on block start
      if (ctrl_i.clear && (INDEX != 0)) begin
        delay_d = '0;
      end else begin
        delay_d = prev_delay_i;
      end
    end else if (ctrl_i.load && idx_hit) begin
      coef_d = coef_wr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      coef_q  <= '0;
    end else begin
      delay_q <= delay_d;
      coef_q  <= coef_d;
    end
  end

  assign delay_o = delay_q;
  assign coef_o  = coef_q;

endmodule

### src/fbc_mac.sv
// Shared multiply-accumulate fed from the tail of the tap ring.
// Depends on fbc_pkg; instantiated by fir_block_convolution.
module fbc_mac import fbc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 16,
  parameter int unsigned ACC_W       = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbc_mac_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  output logic signed [ACC_W-1:0]       acc_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  assign prod_d = sample_i * coef_i;

  // Accumulate the registered product of the previous cycle
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.mult;
      acc_q      <= acc_d;
    end
  end

  // Product register is payload only
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign acc_o = acc_q;

endmodule

### src/fir_block_convolution.sv
// Top level of the block FIR convolution filter: stream ports, sequencer,
// tap cell ring and shared MAC. Depends on fbc_pkg, fbc_cell and fbc_mac.
//
// A load request writes one coefficient and gives no result; an unused
// command is taken and dropped. A sample or flush request shifts the delay
// line, then the row of TAPS cells rotates sample and coefficient pairs
// past one shared multiplier, one tap per cycle. The sequencer then steps
// through its drain and done states, and the 40-bit saturated sum moves to
// the master side output register as it leaves the done state; the next
// request can be taken in the same cycle as that sum appears. The input is
// taken again once the sum has moved to the output register, so a waiting
// result does not stall the next request; only a second sum waits for the
// output register to be read.
// Coefficients and the delay line reset to zero.
module fir_block_convolution import fbc_pkg::*; #(
  parameter int unsigned TAPS        = 101,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // slave side
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,   // coef_index[6:0], coef_value[22:7],
                                            // sample_in[38:23], zero pad [39]
  input  logic [2:0]        s_axis_tuser,   // command[1:0], first_of_block[2]
  // master side
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata    // filtered[39:0]
);

  localparam int unsigned CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned ACC_W  = SAMPLE_BITS + COEF_BITS + $clog2(TAPS + 1);
  localparam int unsigned SAT_W  = (ACC_W > OUT_W + 1) ? ACC_W : OUT_W + 1;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh7F_FFFF_FFFF);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sh80_0000_0000);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_vld_q;
  logic [OUT_W-1:0]   out_q;

  // Request field unpack
  logic [1:0]             cmd;
  logic                   first_blk;
  logic [IDX_W-1:0]       coef_idx;
  logic [FIELD_W-1:0]     coef_val_raw;
  logic [FIELD_W-1:0]     sample_raw;
  logic [COEF_BITS-1:0]   coef_wr;
  logic [SAMPLE_BITS-1:0] sample_val;

  assign cmd          = s_axis_tuser[1:0];
  assign first_blk    = s_axis_tuser[2];
  assign coef_idx     = s_axis_tdata[6:0];
  assign coef_val_raw = s_axis_tdata[22:7];
  assign sample_raw   = s_axis_tdata[38:23];

  // Low bits of the field, zero-extended first when the store is wider
  logic [31:0] coef_ext, sample_ext;
  assign coef_ext   = 32'(coef_val_raw);
  assign sample_ext = 32'(sample_raw);
  assign coef_wr    = coef_ext[COEF_BITS-1:0];
  assign sample_val = (cmd == CMD_SAMPLE) ? sample_ext[SAMPLE_BITS-1:0] : '0;

  // Handshake and cell controls
  logic           req_acc;
  logic           is_filter;
  fbc_cell_ctrl_t cell_ctrl;
  fbc_mac_ctrl_t  mac_ctrl;

  assign s_axis_tready    = (state_q == ST_IDLE);
  assign req_acc          = s_axis_tvalid && s_axis_tready;
  assign is_filter        = (cmd == CMD_SAMPLE) || (cmd == CMD_FLUSH);
  assign cell_ctrl.load   = req_acc && (cmd == CMD_LOAD);
  assign cell_ctrl.shift  = req_acc && is_filter;
  assign cell_ctrl.clear  = req_acc && is_filter && first_blk;
  assign cell_ctrl.rotate = (state_q == ST_RUN);
  assign mac_ctrl.clr     = cell_ctrl.shift;
  assign mac_ctrl.mult    = (state_q == ST_RUN);

  // Tap ring: cell i takes from cell i-1, head takes the sample or the tail
  logic [SAMPLE_BITS-1:0] delay_w [TAPS];
  logic [COEF_BITS-1:0]   coef_w  [TAPS];
  logic [SAMPLE_BITS-1:0] head_delay;

  assign head_delay = cell_ctrl.rotate ? delay_w[TAPS-1] : sample_val;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] prev_delay;
    logic [COEF_BITS-1:0]   prev_coef;
    if (i == 0) begin : g_head
      assign prev_delay = head_delay;
      assign prev_coef  = coef_w[TAPS-1];
    end else begin : g_body
      assign prev_delay = delay_w[i-1];
      assign prev_coef  = coef_w[i-1];
    end
    fbc_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .coef_idx_i   (coef_idx),
      .coef_wr_i    (coef_wr),
      .prev_delay_i (prev_delay),
      .prev_coef_i  (prev_coef),
      .delay_o      (delay_w[i]),
      .coef_o       (coef_w[i])
    );
  end

  // Shared MAC on the ring tail
  logic signed [ACC_W-1:0] acc;

  fbc_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i ($signed(delay_w[TAPS-1])),
    .coef_i   ($signed(coef_w[TAPS-1])),
    .acc_o    (acc)
  );

  // Saturate to the 40-bit output range
  logic signed [SAT_W-1:0] acc_ext;
  logic [OUT_W-1:0]        sat_val;

  assign acc_ext = SAT_W'(acc);

  always_comb begin
    if (acc_ext > SAT_MAX) begin
      sat_val = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (acc_ext < SAT_MIN) begin
      sat_val = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_val = acc_ext[OUT_W-1:0];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // output valid: set when the sum moves over, cleared when taken
      if ((state_q == ST_DONE) && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cell_ctrl.shift) begin
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt_q == CNT_W'(TAPS - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_vld_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && (!out_vld_q || m_axis_tready)) begin
      out_q <= sat_val;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
